// ----- hw/rtl/rstm_pkg.sv -----
// ----------------------------------------------------------------------------
// RTP stream traffic monitor package
// Shared types, constants and a helper function for the monitor.
// ----------------------------------------------------------------------------
`default_nettype none
package rstm_pkg;

  localparam int unsigned DTLS_HEADER_MIN = 13;
  localparam int unsigned RTP_HEADER_MIN  = 12;

  // ceil(2^38 / 1000): exact floor division by 1000 for any 32-bit value.
  localparam logic [29:0] RECIP_1000 = 30'd274877907;
  localparam logic [31:0] RATE_MIN   = 32'd1000;

  typedef enum logic [2:0] {
    KIND_DTLS      = 3'd0,
    KIND_VIDEO     = 3'd1,
    KIND_AUDIO     = 3'd2,
    KIND_UNKNOWN   = 3'd3,
    KIND_OTHER     = 3'd4,
    KIND_VREPORT   = 3'd5,
    KIND_AREPORT   = 3'd6,
    KIND_NOT_READY = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    REG_VIDEO_PT   = 3'd0,
    REG_AUDIO_PT   = 3'd1,
    REG_VIDEO_RATE = 3'd2,
    REG_AUDIO_RATE = 3'd3,
    REG_DELAY      = 3'd4,
    REG_MIN_DUR    = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_START,
    S_DIV_WAIT,
    S_UPDATE,
    S_REPORT,
    S_OUT,
    S_OUT2
  } state_t;

  typedef struct packed {
    logic        action;
    logic [15:0] packet_length;
    logic [31:0] header_word0;
    logic [31:0] header_word1;
    logic [47:0] receive_time_ms;
    logic [31:0] wall_seconds;
  } in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic               stream_start_event;
    logic [31:0]        event_timestamp_ms;
    logic [31:0]        packet_total;
    logic [31:0]        frame_total;
    logic [31:0]        loss_total;
    logic [47:0]        duration_ms;
    logic signed [47:0] latency_ms;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [6:0]  video_payload_type;
    logic [6:0]  audio_payload_type;
    logic [31:0] video_clock_rate;
    logic [31:0] audio_clock_rate;
    logic [7:0]  start_delay_seconds;
    logic [15:0] min_report_duration_ms;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic div_start;
    logic update;
    logic report;
    logic second;
  } cmd_t;

  typedef struct packed {
    logic is_report;
    logic needs_div;
    logic div_done;
    logic two_results;
  } status_t;

  // Missing sequence numbers between the previous and the new sequence.
  function automatic logic [31:0] loss_inc(input logic [15:0] prev, input logic [15:0] seq);
    logic [16:0] cur;
    logic [16:0] nxt;
    cur = {1'b0, seq};
    if (prev > 16'hff00 && seq < 16'hf000) begin
      cur = {1'b1, seq};
    end
    nxt = {1'b0, prev} + 17'd1;
    if (cur > nxt) begin
      return {15'd0, cur - nxt};
    end
    return 32'd0;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rstm_div.sv -----
// ----------------------------------------------------------------------------
// RTP stream traffic monitor divider
// Restoring unsigned 32-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rstm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;

  assign trial = {1'b0, rem, quotient[31]} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= 6'd32;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (!trial[33]) begin
          rem      <= trial[31:0];
          quotient <= {quotient[30:0], 1'b1};
        end else begin
          rem      <= {rem[30:0], quotient[31]};
          quotient <= {quotient[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rstm_datapath.sv -----
// ----------------------------------------------------------------------------
// RTP stream traffic monitor datapath
// Classification, timestamp conversion, track state and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module rstm_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rstm_pkg::cfg_t  cfg,
  input  wire rstm_pkg::cmd_t  cmd,
  input  wire rstm_pkg::in_t   in_data,
  output rstm_pkg::status_t    status,
  output rstm_pkg::out_t       out_data
);

  rstm_pkg::in_t  in_r;
  rstm_pkg::out_t res;
  rstm_pkg::out_t res2;
  rstm_pkg::out_t res_c;
  rstm_pkg::out_t res2_c;
  logic           two_c;
  logic           start_evt;
  logic [2:0]     kind_r;
  logic           use_div;
  logic           two_r;
  logic [61:0]    prod;

  logic        v_run, a_run, start_reported;
  logic [31:0] first_seen;
  logic [15:0] v_prev_seq, a_prev_seq;
  logic [31:0] v_prev_stamp, v_origin_stamp, v_change_stamp;
  logic [47:0] v_origin_time, v_period_begin, v_change_time;
  logic [31:0] v_cnt0, v_cnt1, v_cnt2;
  logic [31:0] a_prev_stamp, a_origin_stamp;
  logic [47:0] a_prev_time, a_origin_time, a_period_begin;
  logic [31:0] a_cnt0, a_cnt1, a_cnt2;

  logic [7:0]  b0;
  logic [6:0]  pt;
  logic [15:0] seq;
  logic        is_dtls, is_rtp;
  logic [2:0]  kind_c;
  logic [31:0] rate_sel;
  logic        div_done;
  logic [31:0] quot;
  logic [31:0] ts;
  logic [47:0] now;
  logic [33:0] wall_diff;
  logic        dly;
  logic        start_v, start_a;
  logic        v_run_n, a_run_n;
  logic [48:0] vdur, adur;
  logic [47:0] vlat, alat;
  logic        rep_ok;

  assign b0      = in_r.header_word0[31:24];
  assign pt      = in_r.header_word0[22:16];
  assign seq     = in_r.header_word0[15:0];
  assign now     = in_r.receive_time_ms;
  assign is_dtls = in_r.packet_length >= 16'(rstm_pkg::DTLS_HEADER_MIN)
                   && b0 > 8'd19 && b0 < 8'd64;
  assign is_rtp  = in_r.packet_length >= 16'(rstm_pkg::RTP_HEADER_MIN) && b0[7:6] == 2'b10;

  always_comb begin
    if (is_dtls) begin
      kind_c = rstm_pkg::KIND_DTLS;
    end else if (!is_rtp) begin
      kind_c = rstm_pkg::KIND_OTHER;
    end else if (pt == cfg.video_payload_type) begin
      kind_c = rstm_pkg::KIND_VIDEO;
    end else if (pt == cfg.audio_payload_type) begin
      kind_c = rstm_pkg::KIND_AUDIO;
    end else begin
      kind_c = rstm_pkg::KIND_UNKNOWN;
    end
  end

  assign rate_sel = (kind_c == rstm_pkg::KIND_VIDEO) ? cfg.video_clock_rate
                                                    : cfg.audio_clock_rate;

  rstm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (in_r.header_word1),
    .divisor  ({8'd0, prod[61:38]}),
    .done     (div_done),
    .quotient (quot)
  );

  assign ts = use_div ? quot : in_r.header_word1;

  assign wall_diff = {2'b00, in_r.wall_seconds} - {2'b00, first_seen};
  assign dly       = $signed(wall_diff) > $signed({26'd0, cfg.start_delay_seconds});
  assign start_v   = !v_run && v_prev_stamp != 32'd0 && v_prev_stamp < ts && dly;
  assign start_a   = !a_run && a_prev_stamp != 32'd0 && a_prev_stamp < ts && dly;
  assign v_run_n   = v_run || (kind_r == rstm_pkg::KIND_VIDEO && start_v);
  assign a_run_n   = a_run || (kind_r == rstm_pkg::KIND_AUDIO && start_a);
  assign start_evt = (kind_r inside {rstm_pkg::KIND_VIDEO, rstm_pkg::KIND_AUDIO,
                                     rstm_pkg::KIND_UNKNOWN})
                     && !start_reported && v_run_n && a_run_n;

  assign vdur   = {1'b0, v_change_time} - {1'b0, v_period_begin};
  assign adur   = {1'b0, a_prev_time} - {1'b0, a_period_begin};
  assign vlat   = v_change_time - v_origin_time - {16'd0, v_change_stamp - v_origin_stamp};
  assign alat   = a_prev_time - a_origin_time - {16'd0, a_prev_stamp - a_origin_stamp};
  assign rep_ok = v_run && a_run && !vdur[48] && !adur[48]
                  && vdur[47:0] >= {32'd0, cfg.min_report_duration_ms}
                  && adur[47:0] >= {32'd0, cfg.min_report_duration_ms};

  always_comb begin
    res_c      = '0;
    res2_c     = '0;
    two_c      = 1'b0;
    res_c.last = 1'b1;
    if (cmd.report) begin
      res_c.kind = rstm_pkg::KIND_NOT_READY;
      if (rep_ok) begin
        two_c               = 1'b1;
        res_c.kind          = rstm_pkg::KIND_VREPORT;
        res_c.last          = 1'b0;
        res_c.packet_total  = v_cnt0;
        res_c.frame_total   = v_cnt1;
        res_c.loss_total    = v_cnt2;
        res_c.duration_ms   = vdur[47:0];
        res_c.latency_ms    = vlat;
        res2_c.kind         = rstm_pkg::KIND_AREPORT;
        res2_c.last         = 1'b1;
        res2_c.packet_total = a_cnt0;
        res2_c.frame_total  = a_cnt1;
        res2_c.loss_total   = a_cnt2;
        res2_c.duration_ms  = adur[47:0];
        res2_c.latency_ms   = alat;
      end
    end else begin
      res_c.kind = kind_r;
      if (start_evt) begin
        res_c.stream_start_event = 1'b1;
        res_c.event_timestamp_ms = ts;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.decode) begin
      kind_r  <= kind_c;
      prod    <= rate_sel * rstm_pkg::RECIP_1000;
      use_div <= (kind_c == rstm_pkg::KIND_VIDEO || kind_c == rstm_pkg::KIND_AUDIO)
                 && rate_sel >= rstm_pkg::RATE_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_run <= 1'b0; a_run <= 1'b0; start_reported <= 1'b0; first_seen <= '0;
      v_prev_seq <= '0; v_prev_stamp <= '0; v_origin_stamp <= '0; v_change_stamp <= '0;
      v_origin_time <= '0; v_period_begin <= '0; v_change_time <= '0;
      v_cnt0 <= '0; v_cnt1 <= '0; v_cnt2 <= '0;
      a_prev_seq <= '0; a_prev_stamp <= '0; a_origin_stamp <= '0;
      a_prev_time <= '0; a_origin_time <= '0; a_period_begin <= '0;
      a_cnt0 <= '0; a_cnt1 <= '0; a_cnt2 <= '0;
      two_r <= 1'b0;
    end else if (cmd.update) begin
      res   <= res_c;
      two_r <= two_c;
      if (kind_r == rstm_pkg::KIND_VIDEO) begin
        if (start_v) begin
          v_run <= 1'b1; v_origin_stamp <= ts; v_origin_time <= now;
          v_period_begin <= now; v_prev_seq <= seq; v_prev_stamp <= ts;
        end else if (!v_run) begin
          v_prev_stamp <= ts;
          if (first_seen == 32'd0) begin
            first_seen <= in_r.wall_seconds;
          end
        end else begin
          v_cnt0 <= v_cnt0 + 32'd1;
          if (v_prev_stamp < ts) begin
            v_cnt1 <= v_cnt1 + 32'd1;
            v_cnt2 <= v_cnt2 + rstm_pkg::loss_inc(v_prev_seq, seq);
            v_prev_seq <= seq; v_prev_stamp <= ts;
            v_change_stamp <= ts; v_change_time <= now;
          end else if (v_prev_stamp == ts) begin
            v_cnt2 <= v_cnt2 + rstm_pkg::loss_inc(v_prev_seq, seq);
            v_prev_seq <= seq;
          end
        end
      end
      if (kind_r == rstm_pkg::KIND_AUDIO) begin
        if (start_a) begin
          a_run <= 1'b1; a_origin_stamp <= ts; a_origin_time <= now;
          a_period_begin <= now; a_prev_seq <= seq; a_prev_stamp <= ts;
          a_prev_time <= now; a_cnt0 <= a_cnt0 + 32'd1;
        end else if (!a_run) begin
          a_prev_stamp <= ts; a_prev_time <= now;
          if (first_seen == 32'd0) begin
            first_seen <= in_r.wall_seconds;
          end
        end else begin
          a_cnt0 <= a_cnt0 + 32'd1;
          if (a_prev_stamp < ts) begin
            a_cnt1 <= a_cnt1 + 32'd1;
            a_cnt2 <= a_cnt2 + rstm_pkg::loss_inc(a_prev_seq, seq);
            a_prev_seq <= seq; a_prev_stamp <= ts; a_prev_time <= now;
          end
        end
      end
      if (start_evt) begin
        start_reported <= 1'b1;
      end
    end else if (cmd.report) begin
      res   <= res_c;
      res2  <= res2_c;
      two_r <= two_c;
      if (rep_ok) begin
        v_period_begin <= v_change_time;
        a_period_begin <= a_prev_time;
        v_cnt0 <= '0; v_cnt1 <= '0; v_cnt2 <= '0;
        a_cnt0 <= '0; a_cnt1 <= '0; a_cnt2 <= '0;
      end
    end
  end

  assign status.is_report   = in_r.action;
  assign status.needs_div   = use_div;
  assign status.div_done    = div_done;
  assign status.two_results = two_r;
  assign out_data           = cmd.second ? res2 : res;

endmodule
`default_nettype wire

// ----- hw/rtl/rstm_ctrl.sv -----
// ----------------------------------------------------------------------------
// RTP stream traffic monitor controller
// Sequences one request through decode, optional division, update or report, and output.
// ----------------------------------------------------------------------------
`default_nettype none
module rstm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire rstm_pkg::status_t status,
  output rstm_pkg::cmd_t         cmd
);

  rstm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rstm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      rstm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = rstm_pkg::S_DECODE;
        end
      end
      rstm_pkg::S_DECODE: begin
        if (status.is_report) begin
          state_next = rstm_pkg::S_REPORT;
        end else begin
          cmd.decode = 1'b1;
          state_next = rstm_pkg::S_DIV_START;
        end
      end
      rstm_pkg::S_DIV_START: begin
        if (status.needs_div) begin
          cmd.div_start = 1'b1;
          state_next    = rstm_pkg::S_DIV_WAIT;
        end else begin
          state_next = rstm_pkg::S_UPDATE;
        end
      end
      rstm_pkg::S_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = rstm_pkg::S_UPDATE;
        end
      end
      rstm_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = rstm_pkg::S_OUT;
      end
      rstm_pkg::S_REPORT: begin
        cmd.report = 1'b1;
        state_next = rstm_pkg::S_OUT;
      end
      rstm_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = status.two_results ? rstm_pkg::S_OUT2 : rstm_pkg::S_IDLE;
        end
      end
      rstm_pkg::S_OUT2: begin
        out_valid  = 1'b1;
        cmd.second = 1'b1;
        if (out_ready) begin
          state_next = rstm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rstm_pkg::S_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("Request taken while a result is pending.");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == rstm_pkg::S_DECODE)
    else $error("Accepted request did not move to decode.");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == rstm_pkg::S_UPDATE
                          || $past(state) == rstm_pkg::S_REPORT))
    else $error("Result shown without an update or report step.");

  a_wait_done: assert property (@(posedge clk) disable iff (rst)
    (state == rstm_pkg::S_DIV_WAIT && !status.div_done) |=> state == rstm_pkg::S_DIV_WAIT)
    else $error("Division wait left before completion.");

endmodule
`default_nettype wire

// ----- hw/rtl/rtp_stream_traffic_monitor.sv -----
// ----------------------------------------------------------------------------
// RTP stream traffic monitor
// Classifies packet headers, tracks video and audio RTP streams and reports.
// An RTP video or audio packet with a converted clock passes through decode, the bit-serial
// timestamp divider, update and output; other packets skip the divider, and report requests
// go through decode, report and output.
// One request is handled at a time: a new request is accepted only after the last
// result is taken; a ready report's second result follows the first.
// Synchronous reset returns configuration to defaults and clears the control and track state.
// ----------------------------------------------------------------------------
`default_nettype none
module rtp_stream_traffic_monitor (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [4:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rstm_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rstm_pkg::out_t      out_data
);

  rstm_pkg::cfg_t    cfg;
  rstm_pkg::cmd_t    cmd;
  rstm_pkg::status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.video_payload_type     <= 7'd96;
      cfg.audio_payload_type     <= 7'd111;
      cfg.video_clock_rate       <= 32'd90000;
      cfg.audio_clock_rate       <= 32'd48000;
      cfg.start_delay_seconds    <= 8'd3;
      cfg.min_report_duration_ms <= 16'd3000;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        rstm_pkg::REG_VIDEO_PT:   cfg.video_payload_type     <= pwdata[6:0];
        rstm_pkg::REG_AUDIO_PT:   cfg.audio_payload_type     <= pwdata[6:0];
        rstm_pkg::REG_VIDEO_RATE: cfg.video_clock_rate       <= pwdata;
        rstm_pkg::REG_AUDIO_RATE: cfg.audio_clock_rate       <= pwdata;
        rstm_pkg::REG_DELAY:      cfg.start_delay_seconds    <= pwdata[7:0];
        rstm_pkg::REG_MIN_DUR:    cfg.min_report_duration_ms <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      rstm_pkg::REG_VIDEO_PT:   prdata = {25'd0, cfg.video_payload_type};
      rstm_pkg::REG_AUDIO_PT:   prdata = {25'd0, cfg.audio_payload_type};
      rstm_pkg::REG_VIDEO_RATE: prdata = cfg.video_clock_rate;
      rstm_pkg::REG_AUDIO_RATE: prdata = cfg.audio_clock_rate;
      rstm_pkg::REG_DELAY:      prdata = {24'd0, cfg.start_delay_seconds};
      rstm_pkg::REG_MIN_DUR:    prdata = {16'd0, cfg.min_report_duration_ms};
      default:                  prdata = 32'd0;
    endcase
  end

  rstm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rstm_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ----- dv/rtp_monitor_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP stream traffic monitor checker
// Predicts classification, start events and reports for every accepted
// request and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module rtp_monitor_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  input  logic           in_valid,
  input  logic           in_ready,
  input  rstm_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  rstm_pkg::out_t out_data,
  output int             fail_count,
  output int             pending
);

  typedef struct {
    logic [31:0] prev_seq;
    logic [31:0] prev_stamp;
    logic [47:0] prev_time;
    logic [31:0] origin_stamp;
    logic [47:0] origin_time;
    logic [47:0] period_begin;
    logic [31:0] change_stamp;
    logic [47:0] change_time;
    logic [31:0] packets;
    logic [31:0] frames;
    logic [31:0] losses;
    logic        running;
  } track_state_t;

  rstm_pkg::cfg_t expected_cfg;
  track_state_t   video;
  track_state_t   audio;
  logic           start_reported;
  logic [31:0]    first_seen;
  rstm_pkg::out_t expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [31:0] stamp_to_ms(logic [31:0] ts, logic [31:0] rate);
    if (rate >= 32'd1000) begin
      return ts / (rate / 32'd1000);
    end
    return ts;
  endfunction

  function automatic void add_losses(ref track_state_t t, input logic [31:0] seq);
    logic [31:0] cur;
    cur = seq;
    if (t.prev_seq > 32'hff00 && cur < 32'hf000) begin
      cur = cur + 32'h10000;
    end
    if (cur > t.prev_seq + 32'd1) begin
      t.losses = t.losses + (cur - (t.prev_seq + 32'd1));
    end
  endfunction

  function automatic void update_track(ref track_state_t t, input logic is_video,
                                       input logic [31:0] seq, input logic [31:0] ts,
                                       input logic [47:0] now, input logic [31:0] wall);
    longint elapsed;
    elapsed = longint'(wall) - longint'(first_seen);
    if (!t.running && t.prev_stamp != 0 && t.prev_stamp < ts
        && elapsed > longint'(expected_cfg.start_delay_seconds)) begin
      t.running = 1'b1;
      t.origin_stamp = ts;
      t.origin_time = now;
      t.period_begin = now;
      t.prev_seq = seq;
      t.prev_stamp = ts;
      t.prev_time = now;
      if (is_video) begin
        return;
      end
    end
    if (!t.running) begin
      t.prev_stamp = ts;
      t.prev_time = now;
      if (first_seen == 0) begin
        first_seen = wall;
      end
      return;
    end
    t.packets = t.packets + 1;
    if (t.prev_stamp < ts) begin
      t.frames = t.frames + 1;
      add_losses(t, seq);
      t.prev_seq = seq;
      t.prev_stamp = ts;
      t.prev_time = now;
      if (is_video) begin
        t.change_stamp = ts;
        t.change_time = now;
      end
    end else if (is_video && t.prev_stamp == ts) begin
      add_losses(t, seq);
      t.prev_seq = seq;
      t.prev_time = now;
    end
  endfunction

  function automatic rstm_pkg::out_t track_report(rstm_pkg::kind_t k, track_state_t t,
                                                  longint dur, longint lat, logic last);
    rstm_pkg::out_t r;
    r = '0;
    r.kind = k;
    r.packet_total = t.packets;
    r.frame_total = t.frames;
    r.loss_total = t.losses;
    r.duration_ms = dur[47:0];
    r.latency_ms = lat[47:0];
    r.last = last;
    return r;
  endfunction

  task automatic queue_result(rstm_pkg::out_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic predict_monitor(rstm_pkg::in_t req);
    rstm_pkg::out_t r;
    logic [7:0]  b0;
    logic [6:0]  pt;
    logic [31:0] seq;
    logic [31:0] ts;
    logic [31:0] vspan;
    logic [31:0] aspan;
    longint vdur;
    longint adur;
    longint vlat;
    longint alat;
    r = '0;
    r.last = 1'b1;
    if (req.action) begin
      r.kind = rstm_pkg::KIND_NOT_READY;
      if (video.running && audio.running) begin
        vdur = longint'(video.change_time) - longint'(video.period_begin);
        adur = longint'(audio.prev_time) - longint'(audio.period_begin);
        if (vdur >= longint'(expected_cfg.min_report_duration_ms)
            && adur >= longint'(expected_cfg.min_report_duration_ms)) begin
          vspan = video.change_stamp - video.origin_stamp;
          aspan = audio.prev_stamp - audio.origin_stamp;
          vlat = (longint'(video.change_time) - longint'(video.origin_time))
               - longint'(vspan);
          alat = (longint'(audio.prev_time) - longint'(audio.origin_time))
               - longint'(aspan);
          queue_result(track_report(rstm_pkg::KIND_VREPORT, video, vdur, vlat, 1'b0));
          queue_result(track_report(rstm_pkg::KIND_AREPORT, audio, adur, alat, 1'b1));
          video.period_begin = video.change_time;
          audio.period_begin = audio.prev_time;
          video.packets = 0; video.frames = 0; video.losses = 0;
          audio.packets = 0; audio.frames = 0; audio.losses = 0;
          return;
        end
      end
      queue_result(r);
      return;
    end
    b0 = req.header_word0[31:24];
    if (req.packet_length >= rstm_pkg::DTLS_HEADER_MIN && b0 > 8'd19 && b0 < 8'd64) begin
      r.kind = rstm_pkg::KIND_DTLS;
    end else if (req.packet_length >= rstm_pkg::RTP_HEADER_MIN && b0[7:6] == 2'b10) begin
      pt = req.header_word0[22:16];
      seq = {16'd0, req.header_word0[15:0]};
      ts = req.header_word1;
      if (pt == expected_cfg.video_payload_type) begin
        r.kind = rstm_pkg::KIND_VIDEO;
        ts = stamp_to_ms(ts, expected_cfg.video_clock_rate);
        update_track(video, 1'b1, seq, ts, req.receive_time_ms, req.wall_seconds);
      end else if (pt == expected_cfg.audio_payload_type) begin
        r.kind = rstm_pkg::KIND_AUDIO;
        ts = stamp_to_ms(ts, expected_cfg.audio_clock_rate);
        update_track(audio, 1'b0, seq, ts, req.receive_time_ms, req.wall_seconds);
      end else begin
        r.kind = rstm_pkg::KIND_UNKNOWN;
      end
      if (!start_reported && video.running && audio.running) begin
        start_reported = 1'b1;
        r.stream_start_event = 1'b1;
        r.event_timestamp_ms = ts;
      end
    end else begin
      r.kind = rstm_pkg::KIND_OTHER;
    end
    queue_result(r);
  endtask

  task automatic report_mismatch(string what, rstm_pkg::out_t got, rstm_pkg::out_t want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic compare_result(rstm_pkg::out_t got);
    rstm_pkg::out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", got, '0);
      return;
    end
    want = expected_results[0];
    expected_results.delete(0);
    if (got.kind != want.kind) report_mismatch("kind", got, want);
    else if (got.stream_start_event != want.stream_start_event)
      report_mismatch("stream_start_event", got, want);
    else if (got.event_timestamp_ms != want.event_timestamp_ms)
      report_mismatch("event_timestamp_ms", got, want);
    else if (got.packet_total != want.packet_total) report_mismatch("packet_total", got, want);
    else if (got.frame_total != want.frame_total) report_mismatch("frame_total", got, want);
    else if (got.loss_total != want.loss_total) report_mismatch("loss_total", got, want);
    else if (got.duration_ms != want.duration_ms) report_mismatch("duration_ms", got, want);
    else if (got.latency_ms != want.latency_ms) report_mismatch("latency_ms", got, want);
    else if (got.last != want.last) report_mismatch("last", got, want);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_cfg <= '{7'd96, 7'd111, 32'd90000, 32'd48000, 8'd3, 16'd3000};
      video <= '{default: '0};
      audio <= '{default: '0};
      start_reported <= 1'b0;
      first_seen <= '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        compare_result(out_data);
      end
      if (in_valid && in_ready) begin
        predict_monitor(in_data);
      end
      if (psel && penable && pwrite) begin
        case (rstm_pkg::reg_index_t'(paddr[4:2]))
          rstm_pkg::REG_VIDEO_PT:   expected_cfg.video_payload_type = pwdata[6:0];
          rstm_pkg::REG_AUDIO_PT:   expected_cfg.audio_payload_type = pwdata[6:0];
          rstm_pkg::REG_VIDEO_RATE: expected_cfg.video_clock_rate = pwdata;
          rstm_pkg::REG_AUDIO_RATE: expected_cfg.audio_clock_rate = pwdata;
          rstm_pkg::REG_DELAY:      expected_cfg.start_delay_seconds = pwdata[7:0];
          rstm_pkg::REG_MIN_DUR:    expected_cfg.min_report_duration_ms = pwdata[15:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP stream traffic monitor testbench
// Drives directed and random packet headers and report requests through
// several register settings and idle patterns; the checker judges results.
// ----------------------------------------------------------------------------
module testbench;

  logic           clk;
  logic           rst;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [4:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;
  logic           in_valid;
  logic           in_ready;
  rstm_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  rstm_pkg::out_t out_data;
  int             fail_count;
  int             pending;
  int             cycle_count;
  int             send_idle;
  int             recv_idle;
  logic [15:0]    video_seq;
  logic [15:0]    audio_seq;
  logic [31:0]    video_stamp;
  logic [31:0]    audio_stamp;
  logic [47:0]    now_ms;
  logic [31:0]    wall;

  rtp_stream_traffic_monitor dut (.*);

  rtp_monitor_checker u_chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .in_valid, .in_ready,
    .in_data, .out_valid, .out_ready, .out_data, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 1500000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(rstm_pkg::reg_index_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(rstm_pkg::in_t req);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic rstm_pkg::in_t rtp_packet(logic [6:0] pt, logic [15:0] seq,
                                               logic [31:0] ts);
    rstm_pkg::in_t r;
    r = '0;
    r.packet_length = 16'($urandom_range(12, 1500));
    r.header_word0 = {2'b10, 6'($urandom), $urandom_range(1) ? 1'b1 : 1'b0, pt, seq};
    r.header_word1 = ts;
    r.receive_time_ms = now_ms;
    r.wall_seconds = wall;
    return r;
  endfunction

  function automatic rstm_pkg::in_t report_request();
    rstm_pkg::in_t r;
    r = '0;
    r.action = 1'b1;
    r.packet_length = 16'($urandom);
    r.header_word0 = $urandom;
    r.header_word1 = $urandom;
    r.receive_time_ms = {16'($urandom), 32'($urandom)};
    r.wall_seconds = $urandom;
    return r;
  endfunction

  function automatic rstm_pkg::in_t noise_packet();
    rstm_pkg::in_t r;
    r = report_request();
    r.action = 1'b0;
    if ($urandom_range(3) == 0) r.packet_length = 16'($urandom_range(15));
    return r;
  endfunction

  task automatic stream_phase(int count, logic [6:0] vpt, logic [6:0] apt);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      now_ms = now_ms + 48'($urandom_range(40));
      if ($urandom_range(9) == 0) wall = wall + 1;
      if (pick < 40) begin
        video_seq = video_seq + 16'($urandom_range(3) == 0 ? $urandom_range(4) : 1);
        if ($urandom_range(2) != 0) video_stamp = video_stamp + $urandom_range(6000);
        send_request(rtp_packet(vpt, video_seq, video_stamp));
      end else if (pick < 75) begin
        audio_seq = audio_seq + 16'($urandom_range(5) == 0 ? $urandom_range(4) : 1);
        audio_stamp = audio_stamp + $urandom_range(2000);
        send_request(rtp_packet(apt, audio_seq, audio_stamp));
      end else if (pick < 85) begin
        send_request(report_request());
      end else if (pick < 90) begin
        send_request(rtp_packet(7'($urandom), 16'($urandom), $urandom));
      end else begin
        send_request(noise_packet());
      end
    end
  endtask

  initial begin
    rstm_pkg::in_t req;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    send_idle = 18;
    recv_idle = 57;
    video_seq = 16'hfff0;
    audio_seq = 16'h0100;
    video_stamp = 32'h0000_1000;
    audio_stamp = 32'h0000_2000;
    now_ms = 48'd1000;
    wall = 32'd10;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    req = '0;
    send_request(req);
    req.action = 1'b1;
    send_request(req);
    req = '1;
    req.action = 1'b0;
    send_request(req);
    req = '0;
    req.packet_length = 16'd13;
    req.header_word0 = 32'h1400_0000;
    send_request(req);
    req.header_word0 = 32'h3f00_0000;
    send_request(req);
    req.packet_length = 16'd12;
    send_request(req);
    req.header_word0 = 32'h8000_0000;
    send_request(req);
    req.packet_length = 16'd11;
    send_request(req);
    req.packet_length = 16'hffff;
    req.header_word0 = 32'hc000_0000;
    send_request(req);
    for (int i = 0; i < 6; i++) begin
      now_ms = now_ms + 48'd1000;
      wall = wall + 32'd2;
      video_seq = video_seq + (i == 3 ? 16'd5 : 16'd1);
      audio_seq = audio_seq + 16'd1;
      video_stamp = video_stamp + 32'd90000;
      audio_stamp = audio_stamp + 32'd48000;
      send_request(rtp_packet(7'd96, video_seq, video_stamp));
      send_request(rtp_packet(7'd111, audio_seq, audio_stamp));
    end
    send_request(report_request());
    send_request(rtp_packet(7'd96, video_seq + 16'd1, video_stamp));
    send_request(rtp_packet(7'd5, 16'hffff, 32'hffff_ffff));
    stream_phase(420, 7'd96, 7'd111);
    wait_idle();

    send_idle = 57;
    recv_idle = 18;
    write_reg(rstm_pkg::REG_VIDEO_PT, 32'd127);
    write_reg(rstm_pkg::REG_AUDIO_PT, 32'd0);
    write_reg(rstm_pkg::REG_VIDEO_RATE, 32'd999);
    write_reg(rstm_pkg::REG_AUDIO_RATE, 32'hffff_ffff);
    write_reg(rstm_pkg::REG_DELAY, 32'd0);
    write_reg(rstm_pkg::REG_MIN_DUR, 32'd0);
    stream_phase(450, 7'd127, 7'd0);
    wait_idle();

    send_idle = 0;
    recv_idle = 0;
    write_reg(rstm_pkg::REG_VIDEO_PT, 32'd1);
    write_reg(rstm_pkg::REG_AUDIO_PT, 32'd2);
    write_reg(rstm_pkg::REG_VIDEO_RATE, 32'd1000);
    write_reg(rstm_pkg::REG_AUDIO_RATE, 32'd0);
    write_reg(rstm_pkg::REG_DELAY, 32'd255);
    write_reg(rstm_pkg::REG_MIN_DUR, 32'd65535);
    stream_phase(150, 7'd1, 7'd2);
    wait_idle();
    write_reg(rstm_pkg::REG_DELAY, 32'd1);
    write_reg(rstm_pkg::REG_MIN_DUR, 32'd500);
    stream_phase(300, 7'd1, 7'd2);
    wait_idle();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
